### rtl/assert_macros.svh
// Assertion macros shared by the list modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ILRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ILRC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### rtl/ilrc_pkg.sv
// Types, codes and constants shared by the list modules.
package ilrc_pkg;

  localparam int unsigned ILRC_DEPTH = 64;
  localparam int unsigned QDEPTH     = 2;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned TOTAL_W  = 7;
  localparam int unsigned CURSOR_W = 6;

  localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_NEXT   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PREV   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_APPEND,
    OP_REMOVE,
    OP_READ,
    OP_NEXT,
    OP_PREV
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SHIFT = 3'b010,
    S_FETCH = 3'b100
  } state_e;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] item_value;
  } ilrc_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  read_value;
    logic [STATUS_W-1:0] status;
    logic [TOTAL_W-1:0]  entry_total;
    logic [CURSOR_W-1:0] cursor_position;
  } ilrc_rsp_t;

  typedef struct packed {
    op_e                op;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] item_value;
  } ilrc_cmd_t;

endpackage

### rtl/ilrc_front.sv
// Front end: accept transfers, decode the mode and queue the commands.
`include "assert_macros.svh"

module ilrc_front import ilrc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  ilrc_req_t req_i,
  output logic      busy,
  output ilrc_cmd_t cmd_o,
  output logic      cmd_valid_o,
  input  logic      cmd_pop_i
);

  localparam int unsigned QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCW = $clog2(QDEPTH + 1);

  ilrc_cmd_t          fifo_q [QDEPTH];
  ilrc_cmd_t          cmd_in;
  logic [QAW-1:0]     wp_q, wp_d, rp_q, rp_d;
  logic [QCW-1:0]     used_q, used_d;
  logic               push;

  // Decode the mode into an operation
  always_comb begin
    cmd_in.position   = req_i.position;
    cmd_in.item_value = req_i.item_value;
    case (req_i.mode)
      MODE_APPEND: cmd_in.op = OP_APPEND;
      MODE_REMOVE: cmd_in.op = OP_REMOVE;
      MODE_READ:   cmd_in.op = OP_READ;
      MODE_NEXT:   cmd_in.op = OP_NEXT;
      MODE_PREV:   cmd_in.op = OP_PREV;
      default:     cmd_in.op = OP_NONE;
    endcase
  end

  assign busy        = (used_q == QCW'(QDEPTH));
  assign push        = start && !busy;
  assign cmd_valid_o = (used_q != '0);
  assign cmd_o       = fifo_q[rp_q];

  // Advance pointers and fill level
  always_comb begin
    wp_d   = wp_q;
    rp_d   = rp_q;
    used_d = used_q;
    if (push) begin
      wp_d = (wp_q == QAW'(QDEPTH - 1)) ? '0 : wp_q + QAW'(1);
    end
    if (cmd_pop_i) begin
      rp_d = (rp_q == QAW'(QDEPTH - 1)) ? '0 : rp_q + QAW'(1);
    end
    if (push && !cmd_pop_i) begin
      used_d = used_q + QCW'(1);
    end else if (!push && cmd_pop_i) begin
      used_d = used_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      used_q <= '0;
    end else begin
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      used_q <= used_d;
    end
  end

  // Store the accepted command
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= cmd_in;
    end
  end

  `ILRC_NEVER(q_pop_empty_a, cmd_pop_i && (used_q == '0), "pop from empty command queue")
  `ILRC_NEVER(q_overfill_a, used_q > QCW'(QDEPTH), "command queue over depth")
  `ILRC_ASSERT(q_busy_hold_a, (busy && !cmd_pop_i) |=> (used_q == QCW'(QDEPTH)), "queue drained without pop")

endmodule

### rtl/ilrc_back.sv
// Back end: list storage, count, cursor and execution of queued commands.
`include "assert_macros.svh"

module ilrc_back import ilrc_pkg::*; #(
  parameter int unsigned DEPTH = ILRC_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ilrc_cmd_t cmd_i,
  input  logic      cmd_valid_i,
  output logic      cmd_pop_o,
  output logic      done_o,
  output ilrc_rsp_t rsp_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned MW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [VALUE_W-1:0] mem_q [DEPTH];
  logic [VALUE_W-1:0] rd_q;
  logic               mem_we;
  logic [AW-1:0]      mem_wa, mem_ra;
  logic [VALUE_W-1:0] mem_wd;

  state_e             state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [AW-1:0]      cursor_q, cursor_d;
  logic [AW-1:0]      wr_q, wr_d;
  ilrc_rsp_t          rsp_q, rsp_d;
  logic               done_q, done_d;

  logic [MW-1:0]       pos_m, cnt_m, wr_m;
  logic [AW-1:0]       cur_fix, idx;
  logic [STATUS_W-1:0] st;
  logic                finish;

  assign cmd_pop_o = cmd_valid_i && (state_q == S_IDLE);
  assign pos_m     = MW'(cmd_i.position);
  assign cnt_m     = MW'(count_q);
  assign wr_m      = MW'(wr_q);
  assign cur_fix   = (CW'(cursor_q) >= count_q) ? '0 : cursor_q;

  // Execute one command, one compaction step or one fetched read
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    cursor_d = cursor_q;
    wr_d     = wr_q;
    rsp_d    = rsp_q;
    done_d   = 1'b0;
    mem_we   = 1'b0;
    mem_wa   = '0;
    mem_wd   = cmd_i.item_value;
    mem_ra   = '0;
    st       = ST_OK;
    finish   = 1'b1;
    idx      = '0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_APPEND: begin
              if (count_q >= CW'(DEPTH)) begin
                st = ST_FULL;
              end else begin
                mem_we  = 1'b1;
                mem_wa  = AW'(count_q);
                count_d = count_q + CW'(1);
              end
            end
            OP_REMOVE: begin
              if (pos_m >= cnt_m) begin
                st = ST_MISS;
              end else begin
                cursor_d = '0;
                if (pos_m + MW'(1) < cnt_m) begin
                  // later entries exist: compact them down one per cycle
                  mem_ra  = AW'(pos_m + MW'(1));
                  wr_d    = AW'(pos_m);
                  state_d = S_SHIFT;
                  finish  = 1'b0;
                end else begin
                  count_d = count_q - CW'(1);
                end
              end
            end
            OP_READ: begin
              cursor_d = cur_fix;
              if (pos_m >= cnt_m) begin
                st = ST_MISS;
              end else begin
                mem_ra   = AW'(pos_m);
                cursor_d = AW'(pos_m);
                state_d  = S_FETCH;
                finish   = 1'b0;
              end
            end
            OP_NEXT, OP_PREV: begin
              if (count_q == '0) begin
                st = ST_MISS;
              end else begin
                if (cmd_i.op == OP_NEXT) begin
                  idx = (CW'(cur_fix) + CW'(1) >= count_q) ? '0 : cur_fix + AW'(1);
                end else begin
                  idx = (cur_fix == '0) ? AW'(count_q - CW'(1)) : cur_fix - AW'(1);
                end
                mem_ra   = idx;
                cursor_d = idx;
                state_d  = S_FETCH;
                finish   = 1'b0;
              end
            end
            default: begin
            end
          endcase
          rsp_d.read_value      = '0;
          rsp_d.status          = st;
          rsp_d.entry_total     = TOTAL_W'(count_d);
          rsp_d.cursor_position = CURSOR_W'(cursor_d);
          done_d                = finish;
        end
      end
      S_SHIFT: begin
        // move the entry read last cycle down one place
        mem_we = 1'b1;
        mem_wa = wr_q;
        mem_wd = rd_q;
        mem_ra = AW'(wr_m + MW'(2));
        if (wr_m + MW'(2) == cnt_m) begin
          count_d           = count_q - CW'(1);
          rsp_d.entry_total = TOTAL_W'(count_d);
          done_d            = 1'b1;
          state_d           = S_IDLE;
        end else begin
          wr_d = wr_q + AW'(1);
        end
      end
      S_FETCH: begin
        rsp_d.read_value = rd_q;
        done_d           = 1'b1;
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      cursor_q <= '0;
      wr_q     <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      wr_q     <= wr_d;
      done_q   <= done_d;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_q <= mem_q[mem_ra];
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `ILRC_NEVER(count_over_a, count_q > CW'(DEPTH), "entry count above depth")
  `ILRC_ASSERT(shift_count_a, (state_q == S_SHIFT) |-> (count_q >= CW'(2)), "compaction with fewer than two entries")
  `ILRC_ASSERT(done_src_a, done_q |-> $past(cmd_pop_o || (state_q != S_IDLE)), "result without a command")
  `ILRC_ASSERT(full_count_a, (done_q && (rsp_q.status == ST_FULL)) |-> (count_q == CW'(DEPTH)), "full status with room left")

endmodule

### rtl/indexed_list_with_rotating_cursor.sv
// Append, miss and unused modes pass from the command queue straight to the registered done_o.
// Read and rotate also hold the back end in the fetch state for the registered memory read.
// Remove at index p with n entries stays in the shift state to move the n-1-p later entries down.
// Throughput: one item per cycle for append when no read, rotate or remove holds the back end.
// Reset clears count, cursor and the command queue at once; entries need no clearing.
// Results are shown on rsp_o for one cycle with done_o and cannot be held off.
module indexed_list_with_rotating_cursor import ilrc_pkg::*; #(
  parameter int unsigned DEPTH = ILRC_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  ilrc_req_t req_i,
  output logic      busy,
  output logic      done_o,
  output ilrc_rsp_t rsp_o
);

  ilrc_cmd_t cmd;
  logic      cmd_valid;
  logic      cmd_pop;

  // Accept and decode transfers into the command queue
  ilrc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .req_i       (req_i),
    .busy        (busy),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  // Execute commands against the list
  ilrc_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

endmodule

### tb/sv/ilrc_list_checker.sv
// Checker for the indexed list: predicts each result and compares it field by field.
module ilrc_list_checker import ilrc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      busy_i,
  input  ilrc_req_t req_i,
  input  logic      done_i,
  input  ilrc_rsp_t rsp_i,
  output int        outstanding_o,
  output int        mismatch_count_o,
  output int        results_seen_o,
  output int        full_hits_o,
  output int        miss_hits_o,
  output int        peak_total_o
);

  // Shadow copy of the list, its entry count and its cursor
  logic [VALUE_W-1:0] list_mem [ILRC_DEPTH];
  int                 list_count;
  int                 list_cursor;

  ilrc_rsp_t expected_rsps [$];
  int        mismatches;
  int        results_seen;
  int        full_hits;
  int        miss_hits;
  int        peak_total;

  // Apply one operation to the shadow list and return the result it should give
  function automatic ilrc_rsp_t apply_list_op(ilrc_req_t op);
    ilrc_rsp_t rsp;
    int        idx;
    int        pos;
    rsp = '0;
    rsp.status = ST_OK;
    pos = int'(op.position);
    case (op.mode)
      MODE_APPEND: begin
        if (list_count >= ILRC_DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          list_mem[list_count] = op.item_value;
          list_count++;
        end
      end
      MODE_REMOVE: begin
        if (pos >= list_count) begin
          rsp.status = ST_MISS;
        end else begin
          // compact the later entries down by one
          for (idx = pos; idx + 1 < list_count; idx++) begin
            list_mem[idx] = list_mem[idx + 1];
          end
          list_count--;
          list_cursor = 0;
        end
      end
      MODE_READ: begin
        if (list_cursor >= list_count) list_cursor = 0;
        if (pos >= list_count) begin
          rsp.status = ST_MISS;
        end else begin
          list_cursor = pos;
          rsp.read_value = list_mem[pos];
        end
      end
      MODE_NEXT, MODE_PREV: begin
        if (list_count == 0) begin
          rsp.status = ST_MISS;
        end else begin
          if (list_cursor >= list_count) list_cursor = 0;
          // wrap around at either end of the list
          if (op.mode == MODE_NEXT) begin
            idx = (list_cursor + 1 >= list_count) ? 0 : list_cursor + 1;
          end else begin
            idx = (list_cursor == 0) ? list_count - 1 : list_cursor - 1;
          end
          list_cursor = idx;
          rsp.read_value = list_mem[idx];
        end
      end
      default: ;
    endcase
    rsp.entry_total     = list_count[TOTAL_W-1:0];
    rsp.cursor_position = list_cursor[CURSOR_W-1:0];
    return rsp;
  endfunction

  // Retire results against the oldest expectation, then queue the new transfer
  always @(posedge clk_i) begin
    ilrc_rsp_t want;
    ilrc_rsp_t got;
    if (!rst_ni) begin
      for (int i = 0; i < ILRC_DEPTH; i++) list_mem[i] = '0;
      list_count   = 0;
      list_cursor  = 0;
      expected_rsps.delete();
      mismatches   = 0;
      results_seen = 0;
      full_hits    = 0;
      miss_hits    = 0;
      peak_total   = 0;
    end else begin
      if (done_i) begin
        got = rsp_i;
        results_seen++;
        if (expected_rsps.size() == 0) begin
          $error("result with nothing expected: read_value %h status %0d", got.read_value,
                 got.status);
          mismatches++;
        end else begin
          want = expected_rsps.pop_front();
          if (got.read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, got.read_value);
            mismatches++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
          end
          if (got.entry_total !== want.entry_total) begin
            $error("entry_total: expected %0d, got %0d", want.entry_total, got.entry_total);
            mismatches++;
          end
          if (got.cursor_position !== want.cursor_position) begin
            $error("cursor_position: expected %0d, got %0d", want.cursor_position,
                   got.cursor_position);
            mismatches++;
          end
        end
      end
      if (start_i && !busy_i) begin
        want = apply_list_op(req_i);
        if (want.status == ST_FULL) full_hits++;
        if (want.status == ST_MISS) miss_hits++;
        if (list_count > peak_total) peak_total = list_count;
        expected_rsps.push_back(want);
      end
    end
    outstanding_o    <= expected_rsps.size();
    mismatch_count_o <= mismatches;
    results_seen_o   <= results_seen;
    full_hits_o      <= full_hits;
    miss_hits_o      <= miss_hits;
    peak_total_o     <= peak_total;
  end

endmodule

### tb/sv/testbench.sv
// Top of the list testbench: clock, reset, operation stimulus and the verdict.
module testbench;
  import ilrc_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam logic [MODE_W-1:0] MODE_SPARE_LO  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_MID = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI  = 3'd7;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  ilrc_req_t req_i = '0;
  logic      busy;
  logic      done_o;
  ilrc_rsp_t rsp_o;

  int outstanding;
  int mismatch_count;
  int results_seen;
  int full_hits;
  int miss_hits;
  int peak_total;
  int items_sent;
  int cycles;

  indexed_list_with_rotating_cursor dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  ilrc_list_checker list_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .req_i            (req_i),
    .done_i           (done_o),
    .rsp_i            (rsp_o),
    .outstanding_o    (outstanding),
    .mismatch_count_o (mismatch_count),
    .results_seen_o   (results_seen),
    .full_hits_o      (full_hits),
    .miss_hits_o      (miss_hits),
    .peak_total_o     (peak_total)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Stop a hung run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic ilrc_req_t make_op(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                                        logic [VALUE_W-1:0] value);
    ilrc_req_t op;
    op.mode       = mode;
    op.position   = pos;
    op.item_value = value;
    return op;
  endfunction

  // Draw a random operation, leaning toward appends while growing, removes otherwise
  function automatic ilrc_req_t pick_list_op(bit growing);
    ilrc_req_t op;
    int        roll;
    int        append_pct;
    int        remove_pct;
    append_pct = growing ? 45 : 12;
    remove_pct = growing ? 10 : 40;
    op.item_value = {$urandom, $urandom};
    roll = $urandom_range(0, 99);
    if (roll < append_pct) begin
      op.mode = MODE_APPEND;
    end else if (roll < append_pct + remove_pct) begin
      op.mode = MODE_REMOVE;
    end else if (roll < append_pct + remove_pct + 20) begin
      op.mode = MODE_READ;
    end else if (roll < append_pct + remove_pct + 31) begin
      op.mode = MODE_NEXT;
    end else if (roll < append_pct + remove_pct + 42) begin
      op.mode = MODE_PREV;
    end else begin
      op.mode = MODE_SPARE_LO + MODE_W'($urandom_range(0, MODE_SPARE_HI - MODE_SPARE_LO));
    end
    // keep most indexes near the live range, with some far out
    case ($urandom_range(0, 9))
      0, 1, 2, 3: op.position = POS_W'($urandom_range(0, 7));
      4, 5, 6, 7: op.position = POS_W'($urandom_range(0, ILRC_DEPTH));
      8:          op.position = POS_W'($urandom_range(0, 255));
      default:    op.position = ($urandom_range(0, 1) != 0) ? POS_W'(ILRC_DEPTH - 1) : '1;
    endcase
    return op;
  endfunction

  // Present one operation and hold it until the block takes the transfer
  task automatic send_op(ilrc_req_t op);
    start <= 1'b1;
    req_i <= op;
    do @(posedge clk_i); while (busy);
    items_sent++;
  endtask

  // Drop start and drive junk on the request while idle
  task automatic idle_for(int gap);
    start <= 1'b0;
    req_i <= $bits(ilrc_req_t)'({$urandom, $urandom, $urandom});
    repeat (gap) @(posedge clk_i);
  endtask

  // Pause until every queued result has come back
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  initial begin
    bit growing;
    int phase_left;
    int burst_left;
    items_sent = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: empty-list misses, unused modes, extreme values, wraps and compaction
    send_op(make_op(MODE_REMOVE, '0, '0));
    send_op(make_op(MODE_READ, '0, '0));
    send_op(make_op(MODE_NEXT, '0, '0));
    send_op(make_op(MODE_PREV, '0, '0));
    send_op(make_op(MODE_SPARE_LO, '1, '1));
    send_op(make_op(MODE_SPARE_HI, '0, '1));
    send_op(make_op(MODE_APPEND, '1, '0));
    send_op(make_op(MODE_APPEND, '0, '1));
    send_op(make_op(MODE_APPEND, 8'd3, 64'h8000_0000_0000_0001));
    send_op(make_op(MODE_APPEND, 8'd0, 64'h0123_4567_89ab_cdef));
    send_op(make_op(MODE_PREV, '0, '1));
    send_op(make_op(MODE_NEXT, '0, '0));
    send_op(make_op(MODE_READ, '1, '0));
    send_op(make_op(MODE_READ, 8'd3, '0));
    send_op(make_op(MODE_NEXT, '1, '0));
    send_op(make_op(MODE_READ, 8'd4, '0));
    send_op(make_op(MODE_REMOVE, 8'd1, '0));
    send_op(make_op(MODE_REMOVE, 8'd3, '0));
    send_op(make_op(MODE_REMOVE, 8'd2, '0));
    send_op(make_op(MODE_PREV, '0, '0));
    send_op(make_op(MODE_READ, 8'd0, '1));
    send_op(make_op(MODE_SPARE_MID, 8'h55, 64'haaaa_5555_aaaa_5555));
    send_op(make_op(MODE_REMOVE, 8'd0, '0));
    send_op(make_op(MODE_REMOVE, 8'd0, '0));
    wait_drained();

    // Random: alternate growing and shrinking phases so the list fills and empties
    growing    = 1'b1;
    phase_left = $urandom_range(150, 220);
    burst_left = $urandom_range(1, 40);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      send_op(pick_list_op(growing));
      phase_left--;
      if (phase_left == 0) begin
        growing    = ~growing;
        phase_left = $urandom_range(40, 200);
      end
      if (n == RANDOM_ITEMS / 3 || n == (2 * RANDOM_ITEMS) / 3) begin
        wait_drained();
      end else begin
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          case ($urandom_range(0, 9))
            0:       idle_for($urandom_range(20, 80));
            1, 2:    ;
            default: idle_for($urandom_range(1, 6));
          endcase
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d operations and checked %0d results.", items_sent, results_seen);
    $display("Saw %0d full-list appends, %0d misses, peak of %0d entries.", full_hits,
             miss_hits, peak_total);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/ilrc_pkg.sv
rtl/ilrc_front.sv
rtl/ilrc_back.sv
rtl/indexed_list_with_rotating_cursor.sv
tb/sv/ilrc_list_checker.sv
tb/sv/testbench.sv
